// ----- design/text_console_char_writer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the text console character writer
// Shared property shapes; every use reports through $error.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCCW_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tccw same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tccw next-cycle check failed");

`endif

// ----- design/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// Types, character codes and defaults for the text console character writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    localparam int ROW_W  = 8;
    localparam int COL_W  = 7;
    localparam int ADDR_W = 11;
    localparam int WORD_W = 16;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ERASE_ATTR   = 8'd15;
    localparam logic [ROW_W-1:0] ROW_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] attribute;
    } char_req_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] cell_address;
        logic [WORD_W-1:0] cell_word;
        logic              off_screen;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } cell_req_t;

endpackage

// ----- design/tccw_stream_if.sv -----
// ----------------------------------------------------------------------------
// tccw_stream_if
// Valid/ready channel carrying one request payload per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tccw_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/text_console_char_writer_unit.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Cursor tracking and cell write generation for a text-mode console.
//
// Channels: chars takes one request (char_code, attribute) per handshake;
// cells returns exactly one request per accepted character, carrying the
// cell write (write_enable, cell_address, cell_word), the off_screen flag
// and the cursor position after that character.
// A result appears on cells in the cycle after its character is accepted.
// Throughput: one character per cycle while cells is not stalled; the cursor
// update and the row*SCREEN_WIDTH+col address are done in the accept cycle.
// Stall: cells holds its request while ready is low; chars stays ready as
// long as the output register is empty or is being drained in that cycle.
// Reset: the cursor returns to row 0, column 0 and the output register is
// emptied. Newline moves to the next row, backspace erases the previous
// cell, any other byte is printed and advances. Rows at or beyond
// SCREEN_HEIGHT are not written (no scrolling) and are flagged off_screen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_char_writer_unit #(
    parameter int SCREEN_WIDTH  = tccw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tccw_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    tccw_stream_if.sink       chars,
    tccw_stream_if.source     cells
);

    localparam int ROW_W = tccw_pkg::ROW_W;
    localparam int COL_W = tccw_pkg::COL_W;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [COL_W:0]   WIDTH_X  = (COL_W+1)'(SCREEN_WIDTH);
    localparam logic [ROW_W-1:0] HEIGHT_X = ROW_W'(SCREEN_HEIGHT);

    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic                out_valid_reg;
    tccw_pkg::cell_req_t out_reg, out_next;

    logic accept;

    assign chars.ready   = !out_valid_reg || cells.ready;
    assign accept        = chars.valid && chars.ready;
    assign cells.valid   = out_valid_reg;
    assign cells.payload = out_reg;

    always_comb
    begin
        logic [7:0]             ch;
        logic [7:0]             attr;
        logic                   do_write;
        logic [ROW_W-1:0]       wr_row;
        logic [COL_W-1:0]       wr_col;
        logic [15:0]            word;
        logic [15:0]            addr_full;
        logic                   on;
        logic [COL_W:0]         col_inc;
        logic [ROW_W-1:0]       row_inc;

        ch       = chars.payload.char_code;
        attr     = chars.payload.attribute;
        row_next = row_reg;
        col_next = col_reg;
        do_write = 1'b0;
        wr_row   = row_reg;
        wr_col   = col_reg;
        word     = '0;
        row_inc  = (row_reg == tccw_pkg::ROW_MAX) ? row_reg : row_reg + 1'b1;
        col_inc  = {1'b0, col_reg} + 1'b1;

        priority if (ch == tccw_pkg::CH_NEWLINE)
        begin
            row_next = row_inc;
            col_next = '0;
        end
        else if (ch == tccw_pkg::CH_BACKSPACE)
        begin
            if (!(row_reg == '0 && col_reg == '0))
            begin
                priority if (col_reg == '0)
                begin
                    row_next = row_reg - 1'b1;
                    col_next = LAST_COL;
                end
                else if ({1'b0, col_reg} >= WIDTH_X)
                begin
                    col_next = LAST_COL;
                end
                else
                begin
                    col_next = col_reg - 1'b1;
                end
                do_write = 1'b1;
                wr_row   = row_next;
                wr_col   = col_next;
                word     = {tccw_pkg::ERASE_ATTR, tccw_pkg::CH_SPACE};
            end
        end
        else
        begin
            do_write = 1'b1;
            word     = {attr, ch};
            // wrap at the screen width
            if (col_inc >= WIDTH_X)
            begin
                col_next = '0;
                row_next = row_inc;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end

        on        = (wr_row < HEIGHT_X) && ({1'b0, wr_col} < WIDTH_X);
        addr_full = 16'(wr_row) * 16'(SCREEN_WIDTH) + 16'(wr_col);

        out_next.write_enable = do_write && on;
        out_next.cell_address = (do_write && on) ? addr_full[tccw_pkg::ADDR_W-1:0] : '0;
        out_next.cell_word    = word;
        out_next.off_screen   = do_write && !on;
        out_next.cursor_row   = row_next;
        out_next.cursor_col   = col_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            // hold the result until it is taken, refill in the same cycle
            if (accept)
                out_valid_reg <= 1'b1;
            else if (cells.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

endmodule

// ----- design/tccw_checker.sv -----
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks on the cell request channel of the console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_char_writer_unit_assert.svh"

module tccw_checker #(
    parameter int SCREEN_WIDTH  = tccw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tccw_pkg::DEF_SCREEN_HEIGHT
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cells_valid,
    input logic                cells_ready,
    input tccw_pkg::cell_req_t cells_payload
);

    localparam logic [tccw_pkg::COL_W:0] WIDTH_X = (tccw_pkg::COL_W+1)'(SCREEN_WIDTH);
    localparam logic [15:0] CELLS = 16'(SCREEN_WIDTH * SCREEN_HEIGHT);

    // a stalled request holds
    `TCCW_ASSERT_NEXT(a_stall_hold, clk, rst_n, cells_valid && !cells_ready, cells_valid && $stable(cells_payload))

    // never both write and suppress
    `TCCW_ASSERT_IMP(a_we_xor_off, clk, rst_n, cells_valid, !(cells_payload.write_enable && cells_payload.off_screen))

    // writes land inside the screen
    `TCCW_ASSERT_IMP(a_addr_range, clk, rst_n, cells_valid && cells_payload.write_enable, 16'(cells_payload.cell_address) < CELLS)

    // cursor column never leaves the row
    `TCCW_ASSERT_IMP(a_col_range, clk, rst_n, cells_valid, {1'b0, cells_payload.cursor_col} < WIDTH_X)

endmodule

bind text_console_char_writer_unit tccw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tccw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cells_valid   (cells.valid),
    .cells_ready   (cells.ready),
    .cells_payload (cells.payload)
);

// ----- tb/sv/tccw_cell_checker.sv -----
// ----------------------------------------------------------------------------
// tccw_cell_checker
// Watches the character and cell channels of the console writer, tracks the
// cursor on its own and compares every cell request with the expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccw_cell_checker
    import tccw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic   clk,
    input  logic   rst_n,
    tccw_stream_if chars,
    tccw_stream_if cells,
    output int     pending,
    output int     mismatches
);

    localparam int SHOWN_MAX = 10;

    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    cell_req_t        cell_queue[$];

    function automatic logic [ROW_W-1:0] next_row(logic [ROW_W-1:0] r);
        return (r == ROW_MAX) ? ROW_MAX : r + 8'd1;
    endfunction

    // Advance the cursor for one character and build the cell request it causes.
    function automatic cell_req_t predict_cell(char_req_t rq);
        cell_req_t         res;
        logic              do_write;
        logic [WORD_W-1:0] word;
        int                wr_row;
        int                wr_col;
        res      = '0;
        do_write = 1'b0;
        word     = '0;
        wr_row   = 0;
        wr_col   = 0;
        if (rq.char_code == CH_NEWLINE)
        begin
            cur_row = next_row(cur_row);
            cur_col = '0;
        end
        else if (rq.char_code == CH_BACKSPACE)
        begin
            if (cur_row != 0 || cur_col != 0)
            begin
                if (cur_col == 0)
                begin
                    cur_row = cur_row - 8'd1;
                    cur_col = COL_W'(SCREEN_WIDTH - 1);
                end
                else if (int'(cur_col) >= SCREEN_WIDTH)
                begin
                    cur_col = COL_W'(SCREEN_WIDTH - 1);
                end
                else
                begin
                    cur_col = cur_col - 7'd1;
                end
                do_write = 1'b1;
                wr_row   = cur_row;
                wr_col   = cur_col;
                word     = {ERASE_ATTR, CH_SPACE};
            end
        end
        else
        begin
            do_write = 1'b1;
            wr_row   = cur_row;
            wr_col   = cur_col;
            word     = {rq.attribute, rq.char_code};
            if (int'(cur_col) + 1 >= SCREEN_WIDTH)
            begin
                cur_col = '0;
                cur_row = next_row(cur_row);
            end
            else
            begin
                cur_col = cur_col + 7'd1;
            end
        end
        if (do_write)
        begin
            res.cell_word = word;
            if (wr_row < SCREEN_HEIGHT && wr_col < SCREEN_WIDTH)
            begin
                res.write_enable = 1'b1;
                res.cell_address = ADDR_W'(wr_row * SCREEN_WIDTH + wr_col);
            end
            else
            begin
                res.off_screen = 1'b1;
            end
        end
        res.cursor_row = cur_row;
        res.cursor_col = cur_col;
        return res;
    endfunction

    task automatic report_cell(input string what, input cell_req_t want, input cell_req_t seen);
        mismatches++;
        if (mismatches <= SHOWN_MAX)
        begin
            $display("%0t %s: expected we=%0b addr=%0d word=%h off=%0b row=%0d col=%0d,"
                     , $time, what, want.write_enable, want.cell_address, want.cell_word,
                     want.off_screen, want.cursor_row, want.cursor_col);
            $display("    got we=%0b addr=%0d word=%h off=%0b row=%0d col=%0d",
                     seen.write_enable, seen.cell_address, seen.cell_word,
                     seen.off_screen, seen.cursor_row, seen.cursor_col);
        end
    endtask

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        cell_req_t want;
        cell_req_t seen;
        if (!rst_n)
        begin
            cur_row = '0;
            cur_col = '0;
            cell_queue.delete();
            pending = 0;
        end
        else
        begin
            if (chars.valid && chars.ready)
                cell_queue.push_back(predict_cell(chars.payload));
            if (cells.valid && cells.ready)
            begin
                seen = cells.payload;
                if (cell_queue.size() == 0)
                begin
                    report_cell("cell request with nothing pending", '0, seen);
                end
                else
                begin
                    want = cell_queue.pop_front();
                    if (seen.write_enable !== want.write_enable
                        || seen.cell_address !== want.cell_address
                        || seen.cell_word !== want.cell_word
                        || seen.off_screen !== want.off_screen
                        || seen.cursor_row !== want.cursor_row
                        || seen.cursor_col !== want.cursor_col)
                        report_cell("cell mismatch", want, seen);
                end
            end
            pending = cell_queue.size();
        end
    end

endmodule

// ----- tb/sv/tb_text_console_char_writer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_text_console_char_writer_unit
// Drives character requests into the console writer with random idling on
// both channels: directed edge cases, on-screen text with erasing, the
// bottom-edge crossing, a long newline run to the row limit, then text there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_char_writer_unit;

    import tccw_pkg::*;

    localparam int SCREEN_WIDTH  = DEF_SCREEN_WIDTH;
    localparam int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 10;

    logic clk;
    logic rst_n;

    tccw_stream_if #(.payload_t(char_req_t)) chars_if ();
    tccw_stream_if #(.payload_t(cell_req_t)) cells_if ();

    int   pending_cells;
    int   mismatch_count;
    int   chars_sent;
    int   at_row;
    int   at_col;
    logic steady_flow;
    logic hold_sink;
    logic sink_held;

    text_console_char_writer_unit #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .cells (cells_if)
    );

    tccw_cell_checker #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars_if),
        .cells      (cells_if),
        .pending    (pending_cells),
        .mismatches (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [7:0] rand_printable();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == CH_NEWLINE || v == CH_BACKSPACE);
        return v;
    endfunction

    // Offer one character; return once it has been taken. The cursor is kept
    // only to steer the stimulus toward the screen edges.
    task automatic send_char(input logic [7:0] code, input logic [7:0] attr);
        int        gap;
        char_req_t rq;
        gap          = pick_gap();
        rq.char_code = code;
        rq.attribute = attr;
        @(negedge clk);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.payload <= rq;
        do
            @(posedge clk);
        while (!chars_if.ready);
        chars_sent++;
        if (code == CH_NEWLINE)
        begin
            at_row = (at_row < 255) ? at_row + 1 : 255;
            at_col = 0;
        end
        else if (code == CH_BACKSPACE)
        begin
            if (at_row != 0 || at_col != 0)
            begin
                if (at_col == 0)
                begin
                    at_row--;
                    at_col = SCREEN_WIDTH - 1;
                end
                else
                begin
                    at_col--;
                end
            end
        end
        else if (at_col == SCREEN_WIDTH - 1)
        begin
            at_col = 0;
            at_row = (at_row < 255) ? at_row + 1 : 255;
        end
        else
        begin
            at_col++;
        end
    endtask

    task automatic send_random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_char(CH_NEWLINE, 8'($urandom));
        else if (r < 22)
            send_char(CH_BACKSPACE, 8'($urandom));
        else
            send_char(rand_printable(), 8'($urandom));
    endtask

    // Hold the input quiet until every cell request has come back.
    task automatic wait_drained();
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (pending_cells != 0)
            @(negedge clk);
    endtask

    // Receiver side: random stalls, plus one long hold when asked.
    initial
    begin : sink_side
        int stall;
        stall          = 0;
        sink_held      = 1'b0;
        cells_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink && !sink_held)
            begin
                sink_held = 1'b1;
                cells_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall > 0)
            begin
                cells_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                cells_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        int   r;
        int   run;
        logic paused;
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.payload = '0;
        chars_sent       = 0;
        at_row           = 0;
        at_col           = 0;
        steady_flow      = 1'b0;
        hold_sink        = 1'b0;
        paused           = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, erase at origin, erase across a row start
        send_char(CH_BACKSPACE, 8'h00);
        send_char(8'hFF, 8'hFF);
        send_char(8'h00, 8'h00);
        send_char(8'h80, 8'h7F);
        send_char(8'h7F, 8'h80);
        send_char(CH_SPACE, 8'hA5);
        send_char(8'h09, 8'h5A);
        send_char(8'h0B, 8'h01);
        send_char(8'h07, 8'hFE);
        repeat (8) send_char(CH_BACKSPACE, 8'($urandom));
        send_char(CH_BACKSPACE, 8'hFF);
        send_char(CH_NEWLINE, 8'hFF);
        send_char(CH_BACKSPACE, 8'h33);
        send_char(8'h41, 8'h1E);
        send_char(CH_NEWLINE, 8'h00);

        // on-screen text with erase runs; stay clear of the bottom edge
        while (chars_sent < 400)
        begin
            if (chars_sent >= 150)
                hold_sink = 1'b1;
            // erase runs can step past a checkpoint, so latch the pause once
            if (chars_sent >= 250 && !paused)
            begin
                paused = 1'b1;
                wait_drained();
            end
            steady_flow = (chars_sent >= 300 && chars_sent < 360);
            r = $urandom_range(0, 99);
            if (at_row >= 20)
            begin
                if (r < 50)
                    send_char(CH_BACKSPACE, 8'($urandom));
                else
                    send_char(rand_printable(), 8'($urandom));
            end
            else if (r < 6)
            begin
                send_char(CH_NEWLINE, 8'($urandom));
            end
            else if (r < 14)
            begin
                run = $urandom_range(1, 12);
                repeat (run) send_char(CH_BACKSPACE, 8'($urandom));
            end
            else
            begin
                send_char(rand_printable(), 8'($urandom));
            end
        end
        steady_flow = 1'b0;

        // cross the bottom edge in both directions
        while (at_row > SCREEN_HEIGHT - 1)
            send_char(CH_BACKSPACE, 8'($urandom));
        while (at_row < SCREEN_HEIGHT - 1)
            send_char(CH_NEWLINE, 8'($urandom));
        while (at_row == SCREEN_HEIGHT - 1)
            send_char(rand_printable(), 8'($urandom));
        send_char(rand_printable(), 8'($urandom));
        send_char(CH_BACKSPACE, 8'($urandom));
        send_char(CH_BACKSPACE, 8'($urandom));
        send_char(CH_NEWLINE, 8'($urandom));
        send_char(CH_NEWLINE, 8'($urandom));
        send_char(CH_BACKSPACE, 8'($urandom));
        repeat (40) send_random_char();

        // run the row up to its ceiling, then keep going there
        while (at_row < 255)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(rand_printable(), 8'($urandom));
            else
                send_char(CH_NEWLINE, 8'($urandom));
        end
        repeat (3) send_char(CH_NEWLINE, 8'($urandom));
        repeat (SCREEN_WIDTH + 5) send_char(rand_printable(), 8'($urandom));
        while (at_col != 0)
            send_char(CH_BACKSPACE, 8'($urandom));
        send_char(CH_BACKSPACE, 8'($urandom));
        repeat (40) send_random_char();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_cells == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
